### src/counting_sort_engine_macros.svh
// assertion macros for the counting sort engine
`ifndef COUNTING_SORT_ENGINE_MACROS_SVH
`define COUNTING_SORT_ENGINE_MACROS_SVH

// same-cycle implication checked on every rising edge out of reset
`define CSE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication checked on every rising edge out of reset
`define CSE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/cse_pkg.sv
// shared types and constants for the counting sort engine
`default_nettype none

package cse_pkg;

  localparam int KEY_W  = 7;
  localparam int DATA_W = 8;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_PULL   = 1'b1;

  typedef struct packed {
    logic clear_step;
    logic ins_issue;
    logic ins_commit;
    logic scan_start;
    logic scan_step;
    logic pull_commit;
    logic set_empty;
    logic out_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic addr_last;
    logic key_ok;
    logic total_zero;
    logic total_full;
    logic hit;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

### src/counting_sort_engine.sv
// top level: counting sort engine with controller and bin datapath
// insert does a registered read of the key's bin, then writes it back
// pull scans the bins onward from the scan pointer;
//   the scan reads one bin per cycle through the single memory read port
// a pull on an empty store skips the scan; its empty result then sits in the output register
// after reset a clearing pass over all KEY_RANGE bins zeroes them; no item is taken meanwhile
`default_nettype none

`include "counting_sort_engine_macros.svh"

module counting_sort_engine #(
  parameter int KEY_RANGE = 128,
  parameter int MAX_ITEMS = 4096
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  input  wire logic [cse_pkg::DATA_W-1:0]  in_tdata,   // key[6:0], pad[7]
  input  wire logic [0:0]                  in_tuser,   // cmd[0]
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  output logic [cse_pkg::DATA_W-1:0]       out_tdata,  // value[6:0], pad[7]
  output logic                             out_tlast,
  output logic [0:0]                       out_tuser   // empty_res[0]
);

  cse_pkg::ctl_cmd_t   cmd;
  cse_pkg::dp_status_t status;

  cse_controller u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_cmd    (in_tuser[0]),
    .status    (status),
    .cmd       (cmd)
  );

  cse_datapath #(
    .KEY_RANGE (KEY_RANGE),
    .MAX_ITEMS (MAX_ITEMS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_key     (in_tdata[cse_pkg::KEY_W-1:0]),
    .cmd        (cmd),
    .status     (status),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  `CSE_ASSERT_NOW(a_empty_payload, out_tvalid && out_tuser[0], !out_tlast && out_tdata == '0, "empty result carries a payload")
  `CSE_ASSERT_NOW(a_commit_hit, cmd.pull_commit, status.hit && !status.total_zero, "pull commit without a stored key")
  `CSE_ASSERT_NOW(a_ins_room, cmd.ins_commit, !status.total_full, "insert commit on a full store")
  `CSE_ASSERT_NEXT(a_out_load, cmd.out_load, out_tvalid, "loaded result not presented")

endmodule

`default_nettype wire

### src/cse_controller.sv
// control state machine for the counting sort engine
`default_nettype none

module cse_controller (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_tvalid,
  output logic                 in_tready,
  input  wire logic            in_cmd,
  input  cse_pkg::dp_status_t  status,
  output cse_pkg::ctl_cmd_t    cmd
);

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_INS   = 5'b00100,
    ST_SCAN  = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (status.addr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (in_cmd == cse_pkg::CMD_PULL) begin
            if (status.total_zero) begin
              cmd.set_empty = 1'b1;
              state_nxt     = ST_EMIT;
            end else begin
              cmd.scan_start = 1'b1;
              state_nxt      = ST_SCAN;
            end
          end else if (status.key_ok && !status.total_full) begin
            cmd.ins_issue = 1'b1;
            state_nxt     = ST_INS;
          end
        end
      end
      ST_INS: begin
        cmd.ins_commit = 1'b1;
        state_nxt      = ST_IDLE;
      end
      ST_SCAN: begin
        if (status.hit) begin
          cmd.pull_commit = 1'b1;
          state_nxt       = ST_EMIT;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

endmodule

`default_nettype wire

### src/cse_datapath.sv
// bin memory, counters, scan address and output register
`default_nettype none

module cse_datapath #(
  parameter int KEY_RANGE = 128,
  parameter int MAX_ITEMS = 4096
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [cse_pkg::KEY_W-1:0]   in_key,
  input  cse_pkg::ctl_cmd_t                cmd,
  output cse_pkg::dp_status_t              status,
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  output logic [cse_pkg::DATA_W-1:0]       out_tdata,
  output logic                             out_tlast,
  output logic [0:0]                       out_tuser
);

  localparam int IDX_W = $clog2(KEY_RANGE);
  localparam int CNT_W = $clog2(MAX_ITEMS + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(KEY_RANGE - 1);

  logic [CNT_W-1:0] bin_mem [KEY_RANGE];

  logic [CNT_W-1:0]          rd_data_r;
  logic [IDX_W-1:0]          rd_idx_r;
  logic                      rd_valid_r;
  logic [IDX_W-1:0]          addr_r;
  logic [IDX_W-1:0]          addr_inc;
  logic [IDX_W-1:0]          ptr_r;
  logic [CNT_W-1:0]          total_r;
  logic                      total_one;
  logic [IDX_W-1:0]          key_idx;
  logic                      rd_en;
  logic [IDX_W-1:0]          rd_addr;
  logic                      wr_en;
  logic [IDX_W-1:0]          wr_addr;
  logic [CNT_W-1:0]          wr_data;
  logic [cse_pkg::KEY_W-1:0] res_value_r;
  logic                      res_last_r;
  logic                      res_empty_r;
  logic                      out_valid_r;
  logic [cse_pkg::KEY_W-1:0] out_value_r;
  logic                      out_last_r;
  logic                      out_empty_r;

  assign key_idx   = IDX_W'(in_key);
  assign addr_inc  = (addr_r == LAST_IDX) ? '0 : addr_r + IDX_W'(1);
  assign total_one = (total_r == CNT_W'(1));

  assign rd_en   = cmd.ins_issue | cmd.scan_step;
  assign rd_addr = cmd.ins_issue ? key_idx : addr_r;
  assign wr_en   = cmd.clear_step | cmd.ins_commit | cmd.pull_commit;
  assign wr_addr = cmd.clear_step ? addr_r : rd_idx_r;

  always_comb begin
    if (cmd.clear_step) begin
      wr_data = '0;
    end else if (cmd.ins_commit) begin
      wr_data = rd_data_r + CNT_W'(1);
    end else begin
      wr_data = rd_data_r - CNT_W'(1);
    end
  end

  // single write port, single registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      bin_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= bin_mem[rd_addr];
      rd_idx_r  <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_valid_r <= 1'b0;
      addr_r     <= '0;
      ptr_r      <= '0;
      total_r    <= '0;
    end else begin
      rd_valid_r <= cmd.scan_step;
      if (cmd.scan_start) begin
        addr_r <= ptr_r;
      end else if (cmd.clear_step || cmd.scan_step) begin
        addr_r <= addr_inc;
      end
      if (cmd.ins_commit) begin
        ptr_r   <= '0;
        total_r <= total_r + CNT_W'(1);
      end else if (cmd.pull_commit) begin
        ptr_r   <= total_one ? '0 : rd_idx_r;
        total_r <= total_r - CNT_W'(1);
      end
    end
  end

  // pending result
  always_ff @(posedge clk) begin
    if (cmd.pull_commit) begin
      res_value_r <= cse_pkg::KEY_W'(rd_idx_r);
      res_last_r  <= total_one;
      res_empty_r <= 1'b0;
    end else if (cmd.set_empty) begin
      res_value_r <= '0;
      res_last_r  <= 1'b0;
      res_empty_r <= 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_value_r <= res_value_r;
      out_last_r  <= res_last_r;
      out_empty_r <= res_empty_r;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = cse_pkg::DATA_W'(out_value_r);
  assign out_tlast    = out_last_r;
  assign out_tuser[0] = out_empty_r;

  assign status.addr_last  = (addr_r == LAST_IDX);
  assign status.key_ok     = (32'(in_key) < 32'(KEY_RANGE));
  assign status.total_zero = (total_r == '0);
  assign status.total_full = (total_r == CNT_W'(MAX_ITEMS));
  assign status.hit        = rd_valid_r && (rd_data_r != '0);
  assign status.out_free   = !out_valid_r || out_tready;

endmodule

`default_nettype wire
